>>> sv/chained_hash_table_core_defines.svh
// assertion macros shared by the hash table core
`ifndef CHAINED_HASH_TABLE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define CHT_ASSERT_IMP(lbl, clk, dis, a, c) \
    lbl: assert property (@(posedge clk) disable iff (dis) (a) |-> (c)) \
        else $error("hash table assertion failed");

// next-cycle implication
`define CHT_ASSERT_NXT(lbl, clk, dis, a, c) \
    lbl: assert property (@(posedge clk) disable iff (dis) (a) |=> (c)) \
        else $error("hash table assertion failed");

`endif

>>> sv/cht_pkg.sv
// shared types and constants of the chained hash table core
package cht_pkg;

    localparam int NUM_BUCKETS_DEF = 256;
    localparam int NUM_NODES_DEF   = 1024;

    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int ACT_W    = 2;
    localparam int STATUS_W = 2;
    localparam int NODE_W   = KEY_W + HASH_W + VALUE_W;

    localparam logic [ACT_W-1:0] ACT_PUT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DEL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic head_rd;
        logic put_commit;
        logic walk_init;
        logic walk_adv;
        logic get_hit;
        logic del_link;
        logic del_free;
        logic set_miss;
        logic set_full;
        logic out_load;
    } cht_cmd_t;

    typedef struct packed {
        logic                 clr_done;
        logic                 mod_done;
        logic [ACT_W-1:0]     act;
        logic                 alloc_ok;
        logic                 cur_ok;
        logic                 match;
        logic                 out_busy;
    } cht_stat_t;

endpackage

>>> sv/chained_hash_table_core.sv
// flow from accept to m_tvalid: bucket unit, head read, then put commits, an unused action
// answers not found, get and delete walk the chain node by node, delete then unlinks and frees
// bucket unit: mask for a power-of-two bucket count, else reciprocal multiplication
// throughput: one request at a time, s_tready returns the cycle after the result is loaded;
// a finished result waits in the output register while the next request is taken
// reset: synchronous active-low; a clearing pass over all NUM_BUCKETS bucket heads blocks requests
`include "chained_hash_table_core_defines.svh"

module chained_hash_table_core #(
    parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF,
    parameter int NUM_NODES   = cht_pkg::NUM_NODES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // key[31:0], hash[63:32], value[95:64]
    input  logic [1:0]   s_tuser,   // action[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // found_value[31:0]
    output logic [1:0]   m_tuser    // status[1:0]
);
    cht_pkg::cht_cmd_t  cmd;
    cht_pkg::cht_stat_t stat;

    cht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cht_datapath #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_NODES(NUM_NODES)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_action (s_tuser),
        .s_key    (s_tdata[31:0]),
        .s_hash   (s_tdata[63:32]),
        .s_value  (s_tdata[95:64]),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_status (m_tuser),
        .m_value  (m_tdata)
    );

    `CHT_ASSERT_IMP(a_zero_value, aclk, !aresetn, m_tvalid && m_tuser != cht_pkg::ST_OK, m_tdata == '0)
    `CHT_ASSERT_NXT(a_one_at_a_time, aclk, !aresetn, s_tvalid && s_tready, !s_tready)
    `CHT_ASSERT_NXT(a_clear_after_reset, aclk, 1'b0, !aresetn, !s_tready && !m_tvalid)
endmodule

>>> sv/cht_ram.sv
// generic single-write, single-read ram with registered read data
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/cht_bucket.sv
// bucket index unit: hash modulo bucket count by mask or reciprocal multiplication
module cht_bucket #(
    parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          start,
    input  logic [cht_pkg::HASH_W-1:0]                    hash_i,
    output logic                                          done,
    output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket
);
    localparam int BW = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
    localparam int HW = cht_pkg::HASH_W;
    localparam bit POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

    generate
        if (POW2) begin : g_mask
            logic          done_reg;
            logic [BW-1:0] bucket_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    bucket_reg <= BW'(hash_i & HW'(NUM_BUCKETS - 1));
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end else begin : g_recip
            // quotient by multiply-high with a rounded-up reciprocal, then remainder
            localparam int SH = $clog2(NUM_BUCKETS);
            localparam logic [63:0] MAGIC_WIDE =
                ((64'd1 << HW) * 64'((1 << SH) - NUM_BUCKETS)) / 64'(NUM_BUCKETS) + 64'd1;
            localparam logic [HW-1:0] MAGIC   = HW'(MAGIC_WIDE);
            localparam logic [HW-1:0] DIVISOR = HW'(NUM_BUCKETS);

            logic [3:0]      stage_reg;
            logic [HW-1:0]   num_reg;
            logic [HW-1:0]   hi_reg;
            logic [HW-1:0]   quot_reg;
            logic [BW-1:0]   rem_reg;
            logic [2*HW-1:0] prod;
            logic [HW-1:0]   half_diff;
            logic [HW-1:0]   rem_full;

            assign prod      = (2*HW)'(num_reg) * (2*HW)'(MAGIC);
            assign half_diff = (num_reg - hi_reg) >> 1;
            assign rem_full  = num_reg - quot_reg * DIVISOR;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stage_reg <= '0;
                end else begin
                    stage_reg <= {stage_reg[2:0], start};
                end
                if (start) begin
                    num_reg <= hash_i;
                end
                if (stage_reg[0]) begin
                    hi_reg <= prod[2*HW-1:HW];
                end
                if (stage_reg[1]) begin
                    quot_reg <= (hi_reg + half_diff) >> (SH - 1);
                end
                if (stage_reg[2]) begin
                    rem_reg <= rem_full[BW-1:0];
                end
            end

            assign done   = stage_reg[3];
            assign bucket = rem_reg;
        end
    endgenerate
endmodule

>>> sv/cht_datapath.sv
// datapath: request registers, bucket and node memories, walk pointers, result register
module cht_datapath #(
    parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF,
    parameter int NUM_NODES   = cht_pkg::NUM_NODES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cht_pkg::cht_cmd_t             cmd,
    output cht_pkg::cht_stat_t            stat,
    input  logic [cht_pkg::ACT_W-1:0]     s_action,
    input  logic [cht_pkg::KEY_W-1:0]     s_key,
    input  logic [cht_pkg::HASH_W-1:0]    s_hash,
    input  logic [cht_pkg::VALUE_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cht_pkg::STATUS_W-1:0]  m_status,
    output logic [cht_pkg::VALUE_W-1:0]   m_value
);
    localparam int BW = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
    localparam int AW = $clog2(NUM_NODES);
    localparam int IW = $clog2(NUM_NODES + 1);
    localparam logic [IW-1:0] NIL = IW'(NUM_NODES);

    logic [cht_pkg::ACT_W-1:0]    act_reg;
    logic [cht_pkg::KEY_W-1:0]    key_reg;
    logic [cht_pkg::HASH_W-1:0]   hash_reg;
    logic [cht_pkg::VALUE_W-1:0]  val_reg;
    logic [BW-1:0]                bucket;
    logic                         mod_done;
    logic [BW-1:0]                clr_cnt_reg;
    logic [IW-1:0]                free_reg;
    logic [IW-1:0]                fresh_reg;
    logic [IW-1:0]                cur_reg;
    logic [IW-1:0]                prev_reg;
    logic [IW-1:0]                steps_reg;
    logic [IW-1:0]                link_reg;
    logic [cht_pkg::STATUS_W-1:0] res_status_reg;
    logic [cht_pkg::VALUE_W-1:0]  res_value_reg;
    logic                         m_valid_reg;
    logic [cht_pkg::STATUS_W-1:0] m_status_reg;
    logic [cht_pkg::VALUE_W-1:0]  m_value_reg;

    logic                         free_ok;
    logic [IW-1:0]                alloc_idx;

    logic                         head_we;
    logic [BW-1:0]                head_waddr;
    logic [IW-1:0]                head_wdata;
    logic [IW-1:0]                head_rdata;

    logic                         node_we;
    logic [cht_pkg::NODE_W-1:0]   node_rdata;
    logic                         next_we;
    logic [AW-1:0]                next_waddr;
    logic [IW-1:0]                next_wdata;
    logic [AW-1:0]                next_raddr;
    logic [IW-1:0]                next_rdata;

    logic [cht_pkg::VALUE_W-1:0]  rd_value;
    logic [cht_pkg::HASH_W-1:0]   rd_hash;
    logic [cht_pkg::KEY_W-1:0]    rd_key;

    cht_bucket #(.NUM_BUCKETS(NUM_BUCKETS)) u_bucket (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.accept),
        .hash_i  (s_hash),
        .done    (mod_done),
        .bucket  (bucket)
    );

    assign free_ok   = free_reg < NIL;
    assign alloc_idx = free_ok ? free_reg : fresh_reg;

    always_comb begin
        head_we    = 1'b0;
        head_waddr = bucket;
        head_wdata = alloc_idx;
        if (cmd.clr_step) begin
            head_we    = 1'b1;
            head_waddr = clr_cnt_reg;
            head_wdata = NIL;
        end else if (cmd.put_commit) begin
            head_we = 1'b1;
        end else if (cmd.del_link && !(prev_reg < NIL)) begin
            head_we    = 1'b1;
            head_wdata = link_reg;
        end
    end

    always_comb begin
        next_we    = 1'b0;
        next_waddr = alloc_idx[AW-1:0];
        next_wdata = head_rdata;
        if (cmd.put_commit) begin
            next_we = 1'b1;
        end else if (cmd.del_link && prev_reg < NIL) begin
            next_we    = 1'b1;
            next_waddr = prev_reg[AW-1:0];
            next_wdata = link_reg;
        end else if (cmd.del_free) begin
            next_we    = 1'b1;
            next_waddr = cur_reg[AW-1:0];
            next_wdata = free_reg;
        end
    end

    assign next_raddr = cmd.head_rd ? free_reg[AW-1:0] : cur_reg[AW-1:0];
    assign node_we    = cmd.put_commit;

    cht_ram #(.WIDTH(IW), .DEPTH(NUM_BUCKETS)) u_head_ram (
        .clk   (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    cht_ram #(.WIDTH(cht_pkg::NODE_W), .DEPTH(NUM_NODES)) u_node_ram (
        .clk   (aclk),
        .we    (node_we),
        .waddr (alloc_idx[AW-1:0]),
        .wdata ({val_reg, hash_reg, key_reg}),
        .raddr (cur_reg[AW-1:0]),
        .rdata (node_rdata)
    );

    cht_ram #(.WIDTH(IW), .DEPTH(NUM_NODES)) u_next_ram (
        .clk   (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    assign {rd_value, rd_hash, rd_key} = node_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            free_reg    <= NIL;
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + BW'(1);
            end
            if (cmd.put_commit) begin
                if (free_ok) begin
                    free_reg <= next_rdata;
                end else begin
                    fresh_reg <= fresh_reg + IW'(1);
                end
            end
            if (cmd.del_free) begin
                free_reg <= cur_reg;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg  <= s_action;
            key_reg  <= s_key;
            hash_reg <= s_hash;
            val_reg  <= s_value;
        end
        if (cmd.walk_init) begin
            cur_reg   <= head_rdata;
            prev_reg  <= NIL;
            steps_reg <= '0;
        end else if (cmd.walk_adv) begin
            prev_reg  <= cur_reg;
            cur_reg   <= next_rdata;
            steps_reg <= steps_reg + IW'(1);
        end
        if (cmd.get_hit || stat.match) begin
            link_reg <= next_rdata;
        end
        if (cmd.set_miss) begin
            res_status_reg <= cht_pkg::ST_NOTFOUND;
            res_value_reg  <= '0;
        end else if (cmd.set_full) begin
            res_status_reg <= cht_pkg::ST_FULL;
            res_value_reg  <= '0;
        end else if (cmd.get_hit) begin
            res_status_reg <= cht_pkg::ST_OK;
            res_value_reg  <= rd_value;
        end else if (cmd.put_commit || cmd.del_free) begin
            res_status_reg <= cht_pkg::ST_OK;
            res_value_reg  <= '0;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_value_reg  <= res_value_reg;
        end
    end

    assign stat.clr_done = clr_cnt_reg == BW'(NUM_BUCKETS - 1);
    assign stat.mod_done = mod_done;
    assign stat.act      = act_reg;
    assign stat.alloc_ok = free_ok || (fresh_reg < NIL);
    assign stat.cur_ok   = (cur_reg < NIL) && (steps_reg != NIL);
    assign stat.match    = (rd_hash == hash_reg) && (rd_key == key_reg);
    assign stat.out_busy = m_valid_reg && !m_ready;

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_value  = m_value_reg;
endmodule

>>> sv/cht_ctrl.sv
// controller state machine sequencing clear, bucket, allocate, walk and unlink steps
module cht_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cht_pkg::cht_stat_t stat,
    output cht_pkg::cht_cmd_t  cmd
);
    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_MOD       = 10'b0000000100,
        S_HEAD_RD   = 10'b0000001000,
        S_HEAD_WAIT = 10'b0000010000,
        S_WALK_RD   = 10'b0000100000,
        S_WALK_CHK  = 10'b0001000000,
        S_DEL_LINK  = 10'b0010000000,
        S_DEL_FREE  = 10'b0100000000,
        S_RESP      = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                if (stat.mod_done) begin
                    if (stat.act == cht_pkg::ACT_PUT || stat.act == cht_pkg::ACT_GET ||
                        stat.act == cht_pkg::ACT_DEL) begin
                        state_next = S_HEAD_RD;
                    end else begin
                        cmd.set_miss = 1'b1;
                        state_next   = S_RESP;
                    end
                end
            end
            S_HEAD_RD: begin
                cmd.head_rd = 1'b1;
                state_next  = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                if (stat.act == cht_pkg::ACT_PUT) begin
                    if (stat.alloc_ok) begin
                        cmd.put_commit = 1'b1;
                    end else begin
                        cmd.set_full = 1'b1;
                    end
                    state_next = S_RESP;
                end else begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (stat.cur_ok) begin
                    state_next = S_WALK_CHK;
                end else begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_WALK_CHK: begin
                if (stat.match) begin
                    if (stat.act == cht_pkg::ACT_GET) begin
                        cmd.get_hit = 1'b1;
                        state_next  = S_RESP;
                    end else begin
                        state_next = S_DEL_LINK;
                    end
                end else begin
                    cmd.walk_adv = 1'b1;
                    state_next   = S_WALK_RD;
                end
            end
            S_DEL_LINK: begin
                cmd.del_link = 1'b1;
                state_next   = S_DEL_FREE;
            end
            S_DEL_FREE: begin
                cmd.del_free = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

>>> verif/chained_hash_table_core_test.sv
// testbench for the chained hash table core: predictor, stream driver and result monitor
`timescale 1ns / 1ps

module chained_hash_table_core_test;

    localparam int NB = cht_pkg::NUM_BUCKETS_DEF;
    localparam int NN = cht_pkg::NUM_NODES_DEF;
    localparam int NIL = NN;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [cht_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [cht_pkg::ACT_W-1:0]   act;
        logic [cht_pkg::KEY_W-1:0]   key;
        logic [cht_pkg::HASH_W-1:0]  hash;
        logic [cht_pkg::VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [cht_pkg::STATUS_W-1:0] status;
        logic [cht_pkg::VALUE_W-1:0]  found_value;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0] m_tuser;
    logic s_tready_q = 1'b0;

    chained_hash_table_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // shadow table
    int unsigned bucket_head[NB];
    logic [cht_pkg::KEY_W-1:0] tbl_key[NN];
    logic [cht_pkg::HASH_W-1:0] tbl_hash[NN];
    logic [cht_pkg::VALUE_W-1:0] tbl_value[NN];
    int unsigned tbl_next[NN];
    int unsigned free_head;
    int unsigned fresh_count;

    request_t pending_requests[$];
    answer_t expected_answers[$];
    logic [cht_pkg::KEY_W-1:0] live_keys[$];
    logic [cht_pkg::HASH_W-1:0] live_hashes[$];

    int mismatches = 0;
    int cycles = 0;
    bit idle_off = 0;
    bit hold_on = 0;
    bit hold_start = 0;
    bit hold_done = 0;
    bit pause_on = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_count = 0;

    function automatic void table_clear();
        for (int i = 0; i < NB; i++) bucket_head[i] = NIL;
        free_head = NIL;
        fresh_count = 0;
    endfunction

    function automatic answer_t table_apply(request_t r);
        answer_t a;
        int unsigned b, cur, prev, n, steps, hit, hit_prev;
        a.status = cht_pkg::ST_NOTFOUND;
        a.found_value = '0;
        b = r.hash % NB;
        if (r.act == cht_pkg::ACT_PUT) begin
            n = NIL;
            if (free_head < NN) begin
                n = free_head;
                free_head = tbl_next[n];
            end else if (fresh_count < NN) begin
                n = fresh_count;
                fresh_count++;
            end
            if (n < NN) begin
                tbl_key[n] = r.key;
                tbl_hash[n] = r.hash;
                tbl_value[n] = r.value;
                tbl_next[n] = bucket_head[b];
                bucket_head[b] = n;
                a.status = cht_pkg::ST_OK;
            end else begin
                a.status = cht_pkg::ST_FULL;
            end
        end else if (r.act == cht_pkg::ACT_GET || r.act == cht_pkg::ACT_DEL) begin
            cur = bucket_head[b];
            prev = NIL;
            steps = 0;
            hit = NIL;
            hit_prev = NIL;
            while (cur < NN && steps < NN && hit == NIL) begin
                if (tbl_hash[cur] == r.hash && tbl_key[cur] == r.key) begin
                    hit = cur;
                    hit_prev = prev;
                end else begin
                    prev = cur;
                    cur = tbl_next[cur];
                    steps++;
                end
            end
            if (hit < NN) begin
                a.status = cht_pkg::ST_OK;
                if (r.act == cht_pkg::ACT_GET) begin
                    a.found_value = tbl_value[hit];
                end else begin
                    if (hit_prev < NN) tbl_next[hit_prev] = tbl_next[hit];
                    else bucket_head[b] = tbl_next[hit];
                    tbl_next[hit] = free_head;
                    free_head = hit;
                end
            end
        end
        return a;
    endfunction

    function automatic request_t make_request(logic [1:0] act, logic [31:0] key,
                                              logic [31:0] hash, logic [31:0] value);
        request_t r;
        r.act = act;
        r.key = key;
        r.hash = hash;
        r.value = value;
        if (act == cht_pkg::ACT_PUT && live_keys.size() < 400) begin
            live_keys.push_back(key);
            live_hashes.push_back(hash);
        end
        return r;
    endfunction

    // random request; requests other than puts mostly use keys already put
    function automatic request_t random_request(int hot_buckets);
        logic [1:0] act;
        logic [31:0] key, hash;
        int sel;
        act = ($urandom_range(0, 99) < 40) ? cht_pkg::ACT_PUT :
              ($urandom_range(0, 1) ? cht_pkg::ACT_GET : cht_pkg::ACT_DEL);
        if ($urandom_range(0, 49) == 0) act = ACT_UNUSED;
        if (act != cht_pkg::ACT_PUT && live_keys.size() > 0 && $urandom_range(0, 99) < 75) begin
            sel = $urandom_range(0, live_keys.size() - 1);
            key = live_keys[sel];
            hash = live_hashes[sel];
            if ($urandom_range(0, 9) == 0) hash ^= 32'h100;
        end else begin
            key = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom;
            hash = $urandom;
            if (hot_buckets > 0) hash[7:0] = 8'($urandom_range(0, hot_buckets - 1));
        end
        return make_request(act, key, hash, $urandom);
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!(s_tvalid && !s_tready_q)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!idle_off && $urandom_range(0, 15) == 0) begin
                    send_gap <= $urandom_range(1, 10);
                    s_tvalid <= 1'b0;
                end else if (!pause_on && pending_requests.size() > 0) begin
                    request_t r;
                    r = pending_requests.pop_front();
                    s_tdata <= {r.value, r.hash, r.key};
                    s_tuser <= r.act;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (hold_on) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 15) == 0) begin
                recv_gap <= $urandom_range(1, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        answer_t got, want;
        cycles <= cycles + 1;
        s_tready_q <= s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                request_t r;
                r.act = s_tuser;
                r.key = s_tdata[31:0];
                r.hash = s_tdata[63:32];
                r.value = s_tdata[95:64];
                expected_answers.push_back(table_apply(r));
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.found_value = m_tdata;
                if (expected_answers.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result status=%0d value=%h",
                                 got.status, got.found_value);
                end else begin
                    want = expected_answers.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected status=%0d value=%h, got status=%0d value=%h",
                                     want.status, want.found_value, got.status, got.found_value);
                    end
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver hold-off, counted in its own process
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_on <= 1'b0;
            hold_count <= 0;
        end else if (hold_on) begin
            hold_count <= hold_count + 1;
            if (hold_count >= HOLD_CYCLES - 1) hold_on <= 1'b0;
        end else if (hold_start && !hold_done) begin
            hold_count <= 0;
            hold_on <= 1'b1;
            hold_done <= 1'b1;
        end
    end

    function automatic bit all_drained();
        return pending_requests.size() == 0 && expected_answers.size() == 0 && !s_tvalid;
    endfunction

    initial begin
        table_clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every action, unused code, duplicates, misses
        pending_requests.push_back(make_request(cht_pkg::ACT_GET, 32'h0, 32'h0, 32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_DEL, 32'h0, 32'h0, 32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_PUT, 32'h0, 32'h0, 32'hFFFFFFFF));
        pending_requests.push_back(make_request(cht_pkg::ACT_PUT, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                                32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_PUT, 32'h0, 32'h0, 32'h12345678));
        pending_requests.push_back(make_request(cht_pkg::ACT_GET, 32'h0, 32'h0, 32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_GET, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                                32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_PUT, 32'h5, 32'h00000100,
                                                32'hA5A5A5A5));
        pending_requests.push_back(make_request(cht_pkg::ACT_GET, 32'h5, 32'h00000000, 32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_GET, 32'h0, 32'h00000100, 32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_DEL, 32'h0, 32'h0, 32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_GET, 32'h0, 32'h0, 32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_DEL, 32'h0, 32'h0, 32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_GET, 32'h0, 32'h0, 32'h0));
        pending_requests.push_back(make_request(ACT_UNUSED, 32'h5, 32'h100, 32'hFFFFFFFF));
        pending_requests.push_back(make_request(cht_pkg::ACT_PUT, 32'h7, 32'h0, 32'h1));
        pending_requests.push_back(make_request(cht_pkg::ACT_DEL, 32'h5, 32'h100, 32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_GET, 32'h7, 32'h0, 32'h0));
        pending_requests.push_back(make_request(cht_pkg::ACT_DEL, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                                32'h0));

        // random, few buckets so chains grow
        for (int i = 0; i < 300; i++)
            pending_requests.push_back(random_request(8));

        // long receiver hold-off while requests keep coming
        while (pending_requests.size() >= 150) @(posedge aclk);
        hold_start = 1'b1;
        while (!hold_done || hold_on) @(posedge aclk);

        // sender pause until everything has drained
        while (pending_requests.size() > 0) @(posedge aclk);
        pause_on = 1'b1;
        for (int i = 0; i < 200; i++)
            pending_requests.push_back(random_request(0));
        while (expected_answers.size() > 0 || s_tvalid) @(posedge aclk);
        pause_on = 1'b0;

        for (int i = 0; i < 380; i++)
            pending_requests.push_back(random_request(16));

        while (pending_requests.size() >= 100) @(posedge aclk);
        idle_off = 1'b1;
        while (!all_drained()) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
